// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk with reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NLC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define NLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/nlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_pkg
// types, character codes and transition functions of the literal recognizers
// ----------------------------------------------------------------------------
package nlc_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UD    = 8'h44;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	typedef enum logic [3:0] {
		IP_LEAD    = 4'd0,
		IP_SIGN    = 4'd1,
		IP_ZERO    = 4'd2,
		IP_OCT     = 4'd3,
		IP_HEXMARK = 4'd4,
		IP_HEX     = 4'd5,
		IP_DEC     = 4'd6,
		IP_TRAIL   = 4'd7,
		IP_FAIL    = 4'd8
	} int_phase_t;

	typedef enum logic [3:0] {
		FP_LEAD    = 4'd0,
		FP_SIGN    = 4'd1,
		FP_MANT    = 4'd2,
		FP_DOT     = 4'd3,
		FP_FRAC    = 4'd4,
		FP_EXP     = 4'd5,
		FP_EXPSIGN = 4'd6,
		FP_EXPDIG  = 4'd7,
		FP_TRAIL   = 4'd8,
		FP_FAIL    = 4'd9
	} float_phase_t;

	// byte classes used by both recognizers
	typedef struct packed {
		logic ws;
		logic sgn;
		logic zero;
		logic dig;
		logic oct;
		logic hex;
		logic xmark;
		logic dot;
		logic expm;
	} char_class_t;

	typedef struct packed {
		float_phase_t phase;
		logic         digit_seen;
	} float_state_t;

	// decode a byte into its classes
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t k;
		k.ws    = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
		k.sgn   = c == CH_PLUS || c == CH_MINUS;
		k.zero  = c == CH_0;
		k.dig   = c >= CH_0 && c <= CH_9;
		k.oct   = c >= CH_0 && c <= CH_7;
		k.hex   = k.dig || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
		k.xmark = c == CH_UX || c == CH_LX;
		k.dot   = c == CH_DOT;
		k.expm  = c == CH_UD || c == CH_LD || c == CH_UE || c == CH_LE;
		return k;
	endfunction

	// integer recognizer transition on a nonzero byte
	function automatic int_phase_t int_next(input int_phase_t p, input char_class_t k);
		int_phase_t tail;
		int_phase_t n;
		tail = k.ws ? IP_TRAIL : IP_FAIL;
		unique case (p)
			IP_LEAD, IP_SIGN: begin
				if (p == IP_LEAD && k.ws)       n = IP_LEAD;
				else if (p == IP_LEAD && k.sgn) n = IP_SIGN;
				else if (k.zero)                n = IP_ZERO;
				else if (k.dig)                 n = IP_DEC;
				else                            n = IP_FAIL;
			end
			IP_ZERO: begin
				if (k.oct)        n = IP_OCT;
				else if (k.xmark) n = IP_HEXMARK;
				else              n = IP_FAIL;
			end
			IP_OCT:     n = k.oct ? IP_OCT : tail;
			IP_HEXMARK: n = k.hex ? IP_HEX : IP_FAIL;
			IP_HEX:     n = k.hex ? IP_HEX : tail;
			IP_DEC:     n = k.dig ? IP_DEC : tail;
			IP_TRAIL:   n = tail;
			default:    n = IP_FAIL;
		endcase
		return n;
	endfunction

	// float recognizer transition on a nonzero byte
	function automatic float_state_t float_next(input float_state_t s, input char_class_t k);
		float_state_t n;
		float_phase_t tail;
		tail = k.ws ? FP_TRAIL : FP_FAIL;
		n.digit_seen = s.digit_seen;
		unique case (s.phase)
			FP_LEAD: begin
				if (k.ws)       n.phase = FP_LEAD;
				else if (k.sgn) n.phase = FP_SIGN;
				else if (k.dig) begin
					n.phase      = FP_MANT;
					n.digit_seen = 1'b1;
				end
				else if (k.dot) n.phase = FP_DOT;
				else            n.phase = FP_FAIL;
			end
			FP_SIGN: begin
				if (k.dig) begin
					n.phase      = FP_MANT;
					n.digit_seen = 1'b1;
				end
				else if (k.dot) n.phase = FP_DOT;
				else            n.phase = tail;
			end
			FP_MANT: begin
				if (k.dig) begin
					n.phase      = FP_MANT;
					n.digit_seen = 1'b1;
				end
				else if (k.dot)                    n.phase = FP_DOT;
				else if (s.digit_seen && k.expm)   n.phase = FP_EXP;
				else                               n.phase = tail;
			end
			FP_DOT: begin
				if (k.dig) begin
					n.phase      = FP_FRAC;
					n.digit_seen = 1'b1;
				end
				else n.phase = FP_FAIL;
			end
			FP_FRAC: begin
				if (k.dig)                       n.phase = FP_FRAC;
				else if (s.digit_seen && k.expm) n.phase = FP_EXP;
				else                             n.phase = tail;
			end
			FP_EXP: begin
				if (k.sgn)      n.phase = FP_EXPSIGN;
				else if (k.dig) n.phase = FP_EXPDIG;
				else            n.phase = tail;
			end
			FP_EXPSIGN, FP_EXPDIG: n.phase = k.dig ? FP_EXPDIG : tail;
			FP_TRAIL:              n.phase = tail;
			default:               n.phase = FP_FAIL;
		endcase
		return n;
	endfunction

	// final verdicts at the terminator
	function automatic logic int_accepts(input int_phase_t p);
		return p == IP_OCT || p == IP_HEX || p == IP_DEC || p == IP_TRAIL;
	endfunction

	function automatic logic float_accepts(input float_phase_t p);
		return p != FP_DOT && p != FP_FAIL && p <= FP_TRAIL;
	endfunction

endpackage

// File: rtl/nlc_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_char_if
// byte channel: one string byte per item
// ----------------------------------------------------------------------------
interface nlc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// File: rtl/nlc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_result_if
// result channel: integer and float verdicts for one string
// ----------------------------------------------------------------------------
interface nlc_result_if;
	logic valid;
	logic ready;
	logic is_integer;
	logic is_float;

	modport source (output valid, output is_integer, output is_float, input ready);
	modport sink (input valid, input is_integer, input is_float, output ready);
endinterface

// File: rtl/nlc_recognizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_recognizer
// integer and float recognizer state, stepped once per byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlc_recognizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] char_code,
	output logic       int_ok,
	output logic       float_ok
);

	nlc_pkg::int_phase_t   int_phase_q;
	nlc_pkg::float_phase_t float_phase_q;
	logic                  digit_seen_q;

	nlc_pkg::char_class_t  cls;
	nlc_pkg::int_phase_t   int_nxt;
	nlc_pkg::float_state_t flt_cur;
	nlc_pkg::float_state_t flt_nxt;
	logic                  terminate;

	// byte decode and transitions
	always_comb begin
		terminate          = char_code == nlc_pkg::CH_NUL;
		cls                = nlc_pkg::classify(char_code);
		flt_cur.phase      = float_phase_q;
		flt_cur.digit_seen = digit_seen_q;
		int_nxt            = nlc_pkg::int_next(int_phase_q, cls);
		flt_nxt            = nlc_pkg::float_next(flt_cur, cls);
	end

	// verdicts from the state before the terminator
	assign int_ok   = nlc_pkg::int_accepts(int_phase_q);
	assign float_ok = nlc_pkg::float_accepts(float_phase_q);

	// state registers, back to start on the terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_phase_q   <= nlc_pkg::IP_LEAD;
			float_phase_q <= nlc_pkg::FP_LEAD;
			digit_seen_q  <= 1'b0;
		end else if (step_en) begin
			if (terminate) begin
				int_phase_q   <= nlc_pkg::IP_LEAD;
				float_phase_q <= nlc_pkg::FP_LEAD;
				digit_seen_q  <= 1'b0;
			end else begin
				int_phase_q   <= int_nxt;
				float_phase_q <= flt_nxt.phase;
				digit_seen_q  <= flt_nxt.digit_seen;
			end
		end
	end

	// checks
	`NLC_ASSERT_NEXT(a_restart, step_en && terminate,
		int_phase_q == nlc_pkg::IP_LEAD && float_phase_q == nlc_pkg::FP_LEAD && !digit_seen_q,
		"recognizers not back at start after terminator")
	`NLC_ASSERT_IMP(a_mant_digit, float_phase_q == nlc_pkg::FP_MANT, digit_seen_q,
		"mantissa phase without a digit seen")
	`NLC_ASSERT_IMP(a_hex_path, int_phase_q == nlc_pkg::IP_HEX,
		$past(int_phase_q) == nlc_pkg::IP_HEXMARK || $past(int_phase_q) == nlc_pkg::IP_HEX,
		"hex phase entered without hex marker")

endmodule

// File: rtl/numeric_literal_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_classifier
// classifies a zero-terminated byte string as integer and/or float literal
// ----------------------------------------------------------------------------
//  channel  | dir | payload                | handshake
//  chars    | in  | char_code[7:0]         | valid/ready, one byte per item
//  result   | out | is_integer, is_float   | valid/ready, one item per string
//
//  A byte is taken every cycle while no terminator waits on a stalled result;
//  the recognizer state steps on each item as it leaves the input register. A
//  zero byte produces its result in the output register at the edge it leaves.
//  Reset puts both recognizers at their leading-whitespace start.
//  A stalled result only holds a terminator in the input register; other
//  bytes keep flowing past a waiting result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numeric_literal_classifier (
	input  logic         clk,
	input  logic         arst_n,
	nlc_char_if.sink     chars,
	nlc_result_if.source result
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       term_s1;
	logic       advance;
	logic       int_ok;
	logic       float_ok;
	logic       out_valid_q;
	logic       is_integer_q;
	logic       is_float_q;

	// a terminator may only leave when the output register is free or its result is taken
	assign term_s1     = char_s1 == nlc_pkg::CH_NUL;
	assign advance     = valid_s1 && (!term_s1 || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	// recognizer state
	nlc_recognizer u_recognizer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.char_code (char_s1),
		.int_ok    (int_ok),
		.float_ok  (float_ok)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term_s1) begin
			is_integer_q <= int_ok;
			is_float_q   <= float_ok;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.is_integer = is_integer_q;
	assign result.is_float   = is_float_q;

	// checks
	`NLC_ASSERT_IMP(a_term_stall, valid_s1 && term_s1 && out_valid_q && !result.ready,
		!chars.ready, "terminator advanced over a pending result")
	`NLC_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(valid_s1 && term_s1),
		"result raised without a terminator")
	`NLC_ASSERT_NEXT(a_in_capture, chars.valid && chars.ready, valid_s1,
		"accepted item missing from input register")

endmodule

// File: verif/literal_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_verdict_checker
// Watches the byte and result channels of the numeric literal classifier.
// It runs its own integer and float recognizers on every accepted byte and
// queues a verdict on each terminator. Every accepted result is compared
// with the oldest queued verdict.
// ----------------------------------------------------------------------------
module literal_verdict_checker (
	input  logic  clk,
	input  logic  arst_n,
	nlc_char_if   chars,
	nlc_result_if result,
	output int    mismatches,
	output int    verdicts_pending,
	output int    strings_checked,
	output int    integers_seen,
	output int    floats_seen
);

	typedef struct packed {
		logic is_integer;
		logic is_float;
	} verdict_t;

	// recognizer state mirrored from the byte stream
	nlc_pkg::int_phase_t   int_ph;
	nlc_pkg::float_phase_t flt_ph;
	logic                  mant_digit_seen;

	verdict_t expected_verdicts[$];

	// step both recognizers on one nonzero byte
	function automatic void advance_recognizers(input logic [7:0] c);
		logic ws, sgn, dig, oct, hex, xmark, dot, expm;
		nlc_pkg::int_phase_t int_tail;
		nlc_pkg::float_phase_t flt_tail;
		ws    = (c >= nlc_pkg::CH_TAB && c <= nlc_pkg::CH_CR) || c == nlc_pkg::CH_SPACE;
		sgn   = c == nlc_pkg::CH_PLUS || c == nlc_pkg::CH_MINUS;
		dig   = c >= nlc_pkg::CH_0 && c <= nlc_pkg::CH_9;
		oct   = c >= nlc_pkg::CH_0 && c <= nlc_pkg::CH_7;
		hex   = dig || (c >= nlc_pkg::CH_UA && c <= nlc_pkg::CH_UF) ||
			(c >= nlc_pkg::CH_LA && c <= nlc_pkg::CH_LF);
		xmark = c == nlc_pkg::CH_UX || c == nlc_pkg::CH_LX;
		dot   = c == nlc_pkg::CH_DOT;
		expm  = c == nlc_pkg::CH_UD || c == nlc_pkg::CH_LD || c == nlc_pkg::CH_UE ||
			c == nlc_pkg::CH_LE;
		int_tail = ws ? nlc_pkg::IP_TRAIL : nlc_pkg::IP_FAIL;
		flt_tail = ws ? nlc_pkg::FP_TRAIL : nlc_pkg::FP_FAIL;

		// integer form
		case (int_ph)
			nlc_pkg::IP_LEAD: begin
				if (ws)                      int_ph = nlc_pkg::IP_LEAD;
				else if (sgn)                int_ph = nlc_pkg::IP_SIGN;
				else if (c == nlc_pkg::CH_0) int_ph = nlc_pkg::IP_ZERO;
				else if (dig)                int_ph = nlc_pkg::IP_DEC;
				else                         int_ph = nlc_pkg::IP_FAIL;
			end
			nlc_pkg::IP_SIGN: begin
				if (c == nlc_pkg::CH_0) int_ph = nlc_pkg::IP_ZERO;
				else if (dig)           int_ph = nlc_pkg::IP_DEC;
				else                    int_ph = nlc_pkg::IP_FAIL;
			end
			nlc_pkg::IP_ZERO: begin
				if (oct)        int_ph = nlc_pkg::IP_OCT;
				else if (xmark) int_ph = nlc_pkg::IP_HEXMARK;
				else            int_ph = nlc_pkg::IP_FAIL;
			end
			nlc_pkg::IP_OCT:     int_ph = oct ? nlc_pkg::IP_OCT : int_tail;
			nlc_pkg::IP_HEXMARK: int_ph = hex ? nlc_pkg::IP_HEX : nlc_pkg::IP_FAIL;
			nlc_pkg::IP_HEX:     int_ph = hex ? nlc_pkg::IP_HEX : int_tail;
			nlc_pkg::IP_DEC:     int_ph = dig ? nlc_pkg::IP_DEC : int_tail;
			nlc_pkg::IP_TRAIL:   int_ph = int_tail;
			default:             int_ph = nlc_pkg::IP_FAIL;
		endcase

		// float form
		case (flt_ph)
			nlc_pkg::FP_LEAD: begin
				if (ws)       flt_ph = nlc_pkg::FP_LEAD;
				else if (sgn) flt_ph = nlc_pkg::FP_SIGN;
				else if (dig) begin
					flt_ph = nlc_pkg::FP_MANT;
					mant_digit_seen = 1'b1;
				end
				else if (dot) flt_ph = nlc_pkg::FP_DOT;
				else          flt_ph = nlc_pkg::FP_FAIL;
			end
			nlc_pkg::FP_SIGN: begin
				if (dig) begin
					flt_ph = nlc_pkg::FP_MANT;
					mant_digit_seen = 1'b1;
				end
				else if (dot) flt_ph = nlc_pkg::FP_DOT;
				else          flt_ph = flt_tail;
			end
			nlc_pkg::FP_MANT: begin
				if (dig) begin
					flt_ph = nlc_pkg::FP_MANT;
					mant_digit_seen = 1'b1;
				end
				else if (dot)                     flt_ph = nlc_pkg::FP_DOT;
				else if (mant_digit_seen && expm) flt_ph = nlc_pkg::FP_EXP;
				else                              flt_ph = flt_tail;
			end
			nlc_pkg::FP_DOT: begin
				if (dig) begin
					flt_ph = nlc_pkg::FP_FRAC;
					mant_digit_seen = 1'b1;
				end
				else flt_ph = nlc_pkg::FP_FAIL;
			end
			nlc_pkg::FP_FRAC: begin
				if (dig)                          flt_ph = nlc_pkg::FP_FRAC;
				else if (mant_digit_seen && expm) flt_ph = nlc_pkg::FP_EXP;
				else                              flt_ph = flt_tail;
			end
			nlc_pkg::FP_EXP: begin
				if (sgn)      flt_ph = nlc_pkg::FP_EXPSIGN;
				else if (dig) flt_ph = nlc_pkg::FP_EXPDIG;
				else          flt_ph = flt_tail;
			end
			nlc_pkg::FP_EXPSIGN, nlc_pkg::FP_EXPDIG:
				flt_ph = dig ? nlc_pkg::FP_EXPDIG : flt_tail;
			nlc_pkg::FP_TRAIL: flt_ph = flt_tail;
			default:           flt_ph = nlc_pkg::FP_FAIL;
		endcase
	endfunction

	// compare results, then track the byte stream
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			int_ph = nlc_pkg::IP_LEAD;
			flt_ph = nlc_pkg::FP_LEAD;
			mant_digit_seen = 1'b0;
			expected_verdicts.delete();
			mismatches = 0;
			verdicts_pending = 0;
			strings_checked = 0;
			integers_seen = 0;
			floats_seen = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result item with no string terminated: is_integer %0b, is_float %0b",
						result.is_integer, result.is_float);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					got.is_integer = result.is_integer;
					got.is_float = result.is_float;
					if (got.is_integer !== want.is_integer) begin
						$error("is_integer: expected %0b, actual %0b", want.is_integer,
							got.is_integer);
						mismatches++;
					end
					if (got.is_float !== want.is_float) begin
						$error("is_float: expected %0b, actual %0b", want.is_float, got.is_float);
						mismatches++;
					end
					strings_checked++;
				end
			end
			if (chars.valid && chars.ready) begin
				if (chars.char_code == nlc_pkg::CH_NUL) begin
					// terminator: judge the string and restart both recognizers
					want.is_integer = int_ph == nlc_pkg::IP_OCT || int_ph == nlc_pkg::IP_HEX ||
						int_ph == nlc_pkg::IP_DEC || int_ph == nlc_pkg::IP_TRAIL;
					want.is_float = flt_ph != nlc_pkg::FP_DOT && flt_ph != nlc_pkg::FP_FAIL;
					expected_verdicts.push_back(want);
					integers_seen += want.is_integer;
					floats_seen += want.is_float;
					int_ph = nlc_pkg::IP_LEAD;
					flt_ph = nlc_pkg::FP_LEAD;
					mant_digit_seen = 1'b0;
				end else begin
					advance_recognizers(chars.char_code);
				end
			end
			verdicts_pending = expected_verdicts.size();
		end
	end
endmodule

// File: verif/numeric_literal_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_classifier_test
// Feeds zero-terminated strings into the classifier: a few hand-picked
// corner strings first, then random integer and float shaped literals,
// damaged literals and byte noise. Both channels idle at random, with
// stretches of full rate. The checker alongside judges every result.
// ----------------------------------------------------------------------------
module numeric_literal_classifier_test;

	localparam int    TOTAL_BYTES = 1850;
	localparam int    MAX_WAIT    = 14;
	localparam int    IDLE_LIMIT  = 2000;
	localparam int    DRAIN_CYCLES = 20;
	localparam string HEX_GLYPHS  = "0123456789abcdefABCDEF";
	localparam string EXP_MARKS   = "DdEe";
	localparam string SOUP_GLYPHS = "+-.0789xXeEdDaAfFgG \t";

	typedef enum int {
		DK_OCT,
		DK_DEC,
		DK_HEX
	} digit_kind_t;

	logic clk;
	logic arst_n;

	nlc_char_if   chars_if();
	nlc_result_if result_if();

	int failures;
	int pending;
	int strings_checked;
	int integers_seen;
	int floats_seen;

	int   bytes_sent = 0;
	int   idle_cycles = 0;
	bit   steady_flow = 1'b0;
	logic [7:0] lit_text[$];

	numeric_literal_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	literal_verdict_checker verdict_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.chars            (chars_if),
		.result           (result_if),
		.mismatches       (failures),
		.verdicts_pending (pending),
		.strings_checked  (strings_checked),
		.integers_seen    (integers_seen),
		.floats_seen      (floats_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("numeric_literal_classifier verification failed");
				$finish;
			end
		end
	end

	// result side: random stall before each item
	initial begin
		int stall;
		result_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
			@(negedge clk);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
		end
	end

	// one byte with a random gap ahead of it
	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			chars_if.char_code <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_code <= c;
		do @(posedge clk); while (!chars_if.ready);
		bytes_sent++;
	endtask

	// current text, then its terminator
	task automatic send_literal();
		foreach (lit_text[i])
			send_byte(lit_text[i]);
		send_byte(nlc_pkg::CH_NUL);
	endtask

	task automatic load_text(input string s);
		lit_text.delete();
		for (int i = 0; i < s.len(); i++)
			lit_text.push_back(s[i]);
	endtask

	function automatic void add_blanks(input int most);
		int pick;
		repeat ($urandom_range(0, most)) begin
			pick = $urandom_range(0, 5);
			lit_text.push_back(pick == 5 ? nlc_pkg::CH_SPACE : 8'(nlc_pkg::CH_TAB + pick));
		end
	endfunction

	function automatic void add_sign();
		if ($urandom_range(0, 2) == 0)
			lit_text.push_back($urandom_range(0, 1) ? nlc_pkg::CH_PLUS : nlc_pkg::CH_MINUS);
	endfunction

	function automatic void add_digits(input int count, input digit_kind_t kind);
		repeat (count) begin
			case (kind)
				DK_OCT:  lit_text.push_back(8'(nlc_pkg::CH_0 + $urandom_range(0, 7)));
				DK_DEC:  lit_text.push_back(8'(nlc_pkg::CH_0 + $urandom_range(0, 9)));
				default: lit_text.push_back(HEX_GLYPHS[$urandom_range(0, HEX_GLYPHS.len() - 1)]);
			endcase
		end
	endfunction

	// random string: mostly literal shaped, some damaged, some noise
	function automatic void compose_literal();
		int shape;
		int spot;
		lit_text.delete();
		shape = $urandom_range(0, 9);
		if (shape <= 2 || shape == 7) begin
			// integer shaped: decimal, octal or hex body
			add_blanks(2);
			add_sign();
			case ($urandom_range(0, 2))
				0: begin
					lit_text.push_back(8'(nlc_pkg::CH_0 + $urandom_range(1, 9)));
					add_digits($urandom_range(0, 4), DK_DEC);
				end
				1: begin
					lit_text.push_back(nlc_pkg::CH_0);
					add_digits($urandom_range(0, 4), DK_OCT);
				end
				default: begin
					lit_text.push_back(nlc_pkg::CH_0);
					lit_text.push_back($urandom_range(0, 1) ? nlc_pkg::CH_UX : nlc_pkg::CH_LX);
					add_digits($urandom_range(0, 4), DK_HEX);
				end
			endcase
			add_blanks(2);
		end else if (shape <= 5 || shape == 8) begin
			// float shaped: mantissa, optional fraction, optional exponent
			add_blanks(2);
			add_sign();
			add_digits($urandom_range(0, 4), DK_DEC);
			if ($urandom_range(0, 1)) begin
				lit_text.push_back(nlc_pkg::CH_DOT);
				add_digits($urandom_range(0, 3), DK_DEC);
			end
			if ($urandom_range(0, 1)) begin
				lit_text.push_back(EXP_MARKS[$urandom_range(0, 3)]);
				add_sign();
				add_digits($urandom_range(0, 3), DK_DEC);
			end
			add_blanks(2);
		end else if (shape == 6) begin
			// raw noise over the whole nonzero byte range
			repeat ($urandom_range(0, 8))
				lit_text.push_back(8'($urandom_range(1, 255)));
		end else begin
			// mix of the characters that matter to the recognizers
			repeat ($urandom_range(0, 6))
				lit_text.push_back(SOUP_GLYPHS[$urandom_range(0, SOUP_GLYPHS.len() - 1)]);
		end

		// damage a well-formed literal with one stray byte
		if (shape == 7 || shape == 8) begin
			if (lit_text.size() == 0 || $urandom_range(0, 1)) begin
				spot = $urandom_range(0, lit_text.size());
				lit_text.insert(spot, 8'($urandom_range(1, 255)));
			end else begin
				spot = $urandom_range(0, lit_text.size() - 1);
				lit_text[spot] = 8'($urandom_range(1, 255));
			end
		end
	endfunction

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = nlc_pkg::CH_NUL;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty string and lone sign count as floats
		load_text("");
		send_literal();
		load_text("+");
		send_literal();
		// lone zero is no integer
		load_text("0");
		send_literal();
		// exponent marker with no digits
		load_text("1e");
		send_literal();
		// dot with no fraction digits
		load_text("5.");
		send_literal();
		// top of the byte range is never a digit
		lit_text = {8'hFF, nlc_pkg::CH_7};
		send_literal();
		// padded octal, hex and a bare fraction
		load_text(" 07\t");
		send_literal();
		load_text("0xF");
		send_literal();
		load_text(".5");
		send_literal();

		while (bytes_sent < TOTAL_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				steady_flow = !steady_flow;
			compose_literal();
			send_literal();
		end
		@(negedge clk);
		chars_if.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d bytes forming %0d strings, all results compared", bytes_sent,
			strings_checked);
		$display("%0d strings judged integer literals, %0d judged float literals",
			integers_seen, floats_seen);
		if (failures == 0 && pending == 0) begin
			$display("numeric_literal_classifier verification clean");
		end else begin
			$display("numeric_literal_classifier verification failed");
		end
		$finish;
	end
endmodule
